### src/ecf_pkg.sv
// ----------------------------------------------------------------------------
// ecf_pkg: shared constants and helpers for the eased RGB565 color fade
// Holds reset values, step counts and the channel extraction helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ecf_pkg;

  // Reset values of the color state and the fade length.
  localparam logic [15:0] COLOR_RESET    = 16'h4DDF;
  localparam logic [15:0] DURATION_RESET = 16'd400;

  // Q0.16 one, as a 17-bit value.
  localparam logic [16:0] Q16_ONE = 17'h10000;

  // Last step index of the bit-serial divider and multiplier, and of the mix lanes.
  localparam logic [3:0] LAST_WORD_STEP = 4'd15;
  localparam logic [3:0] LAST_MIX_STEP  = 4'd5;

  // Input kind codes.
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  // Channel lanes.
  localparam int NUM_CH = 3;
  localparam int CH_R   = 0;
  localparam int CH_G   = 1;
  localparam int CH_B   = 2;

  // Returns one 5/6/5 channel of an RGB565 color, zero-extended to 6 bits.
  function automatic logic [5:0] chan(input logic [15:0] color, input int idx);
    logic [5:0] v;
    v = {1'b0, color[4:0]};
    if (idx == CH_R) begin
      v = {1'b0, color[15:11]};
    end else if (idx == CH_G) begin
      v = color[10:5];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### src/eased_rgb565_color_fade.sv
// ----------------------------------------------------------------------------
// eased_rgb565_color_fade: cubic ease-in-out fade between RGB565 colors
// Set-target items latch a new goal, ticks advance the shown color along an
// eased curve, computed with a bit-serial divider and shift-add multipliers.
// ----------------------------------------------------------------------------
// Flow: a set-target item or a tick at or past the fade end goes straight to the
// output state; a tick inside the fade first runs 16 divider steps, 2 x 16 cube
// steps, 6 mix steps and 5 single steps for fold, reload, ease, color assembly
// and output, and any item may wait for a busy output register.
// One item in flight: the next is accepted once the last leaves S_OUT.
// Synchronous active-high reset: colors 0x4DDF, fade start 0, duration 400 ms.
`default_nettype none

module eased_rgb565_color_fade
  import ecf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,   // fade_duration_ms
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,    // [31:0] now_ms, [47:32] new_color
  input  wire logic        s_tuser,    // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata     // [15:0] shown_color
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_PREP, S_SQR, S_LOAD, S_CUBE, S_EASE, S_MIX, S_FIN, S_OUT
  } state_t;

  state_t state;

  // Architectural state.
  logic [15:0] dur;
  logic [15:0] from_color;
  logic [15:0] goal_color;
  logic [15:0] held_color;
  logic [31:0] fade_start_ms;

  // Datapath registers.
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] xval;
  logic        upper;
  logic [31:0] mul_mcand;
  logic [31:0] mul_hi;
  logic [15:0] mul_lo;
  logic [16:0] ease;
  logic [17:0] lane_hi  [NUM_CH];
  logic [5:0]  lane_lo  [NUM_CH];
  logic        lane_neg [NUM_CH];

  // Combinational helpers.
  logic [31:0] elapsed;
  logic        fade_over;
  logic [16:0] div_shift;
  logic        div_ge;
  logic [16:0] div_sub;
  logic [15:0] x_next;
  logic [32:0] mul_sum;
  logic [16:0] cube_c;
  logic [16:0] ease_next;
  logic [18:0] lane_sum [NUM_CH];
  logic [6:0]  lane_d   [NUM_CH];
  logic [5:0]  lane_mag [NUM_CH];
  logic [5:0]  lane_out [NUM_CH];
  logic [15:0] mix_color;

  assign s_tready = (state == S_IDLE);

  // Elapsed time and the end-of-fade check on an accepted tick.
  always_comb begin
    elapsed   = s_tdata[31:0] - fade_start_ms;
    fade_over = (dur == 16'd0) || (elapsed >= {16'd0, dur});
  end

  // One restoring division step: one quotient bit per cycle.
  always_comb begin
    div_shift = {rem, 1'b0};
    div_ge    = (div_shift >= {1'b0, dur});
    div_sub   = div_shift - {1'b0, dur};
  end

  // Fold the upper half of the curve onto the lower half: x = t or 1 - t.
  always_comb begin
    x_next = quo[15] ? 16'(Q16_ONE - {1'b0, quo}) : quo;
  end

  // Shift-add multiplier step and the eased fraction taken from x^3.
  always_comb begin
    mul_sum   = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, mul_mcand} : 33'd0);
    cube_c    = mul_hi[30:14];
    ease_next = upper ? (Q16_ONE - cube_c) : cube_c;
  end

  // Per-channel lanes: difference, magnitude, mix step and final value.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      lane_d[i]   = {1'b0, chan(goal_color, i)} - {1'b0, chan(from_color, i)};
      lane_mag[i] = lane_d[i][6] ? 6'(-lane_d[i]) : lane_d[i][5:0];
      lane_sum[i] = {1'b0, lane_hi[i]} + (lane_lo[i][0] ? {2'b0, ease} : 19'd0);
      lane_out[i] = lane_neg[i] ? (chan(from_color, i) - lane_hi[i][15:10])
                                : (chan(from_color, i) + lane_hi[i][15:10]);
    end
    mix_color = {lane_out[CH_R][4:0], lane_out[CH_G], lane_out[CH_B][4:0]};
  end

  // Sequencer, state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      dur           <= DURATION_RESET;
      from_color    <= COLOR_RESET;
      goal_color    <= COLOR_RESET;
      held_color    <= COLOR_RESET;
      fade_start_ms <= 32'd0;
      cnt           <= 4'd0;
    end else begin
      if (cfg_we) begin
        dur <= cfg_data;
      end
      // The output stage reloads the register itself when it fires.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == KIND_TARGET) begin
              from_color    <= held_color;
              goal_color    <= s_tdata[47:32];
              fade_start_ms <= s_tdata[31:0];
              state         <= S_OUT;
            end else if (fade_over) begin
              held_color <= goal_color;
              state      <= S_OUT;
            end else begin
              rem   <= elapsed[15:0];
              cnt   <= 4'd0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem <= div_ge ? div_sub[15:0] : div_shift[15:0];
          quo <= {quo[14:0], div_ge};
          cnt <= cnt + 4'd1;
          if (cnt == LAST_WORD_STEP) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // Square x first: multiplicand x, multiplier x.
          xval      <= x_next;
          upper     <= quo[15];
          mul_mcand <= {16'd0, x_next};
          mul_hi    <= 32'd0;
          mul_lo    <= x_next;
          cnt       <= 4'd0;
          state     <= S_SQR;
        end
        S_SQR: begin
          mul_hi <= mul_sum[32:1];
          mul_lo <= {mul_sum[0], mul_lo[15:1]};
          cnt    <= cnt + 4'd1;
          if (cnt == LAST_WORD_STEP) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          // Then x^2 times x.
          mul_mcand <= {mul_hi[15:0], mul_lo};
          mul_hi    <= 32'd0;
          mul_lo    <= xval;
          cnt       <= 4'd0;
          state     <= S_CUBE;
        end
        S_CUBE: begin
          mul_hi <= mul_sum[32:1];
          mul_lo <= {mul_sum[0], mul_lo[15:1]};
          cnt    <= cnt + 4'd1;
          if (cnt == LAST_WORD_STEP) begin
            state <= S_EASE;
          end
        end
        S_EASE: begin
          ease <= ease_next;
          for (int i = 0; i < NUM_CH; i++) begin
            lane_hi[i]  <= 18'd0;
            lane_lo[i]  <= lane_mag[i];
            lane_neg[i] <= lane_d[i][6];
          end
          cnt   <= 4'd0;
          state <= S_MIX;
        end
        S_MIX: begin
          for (int i = 0; i < NUM_CH; i++) begin
            lane_hi[i] <= lane_sum[i][18:1];
            lane_lo[i] <= {lane_sum[i][0], lane_lo[i][5:1]};
          end
          cnt <= cnt + 4'd1;
          if (cnt == LAST_MIX_STEP) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          held_color <= mix_color;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= held_color;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted transaction always takes the block out of idle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("block still ready after accepting a transaction");

  // The divider remainder stays below the duration.
  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> {1'b0, rem} < {1'b0, dur})
    else $error("divider remainder not below duration");

  // The folded cube never exceeds one half in Q0.16.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EASE |-> cube_c <= 17'h08000)
    else $error("eased fraction out of range");

  // A result that finds the output register free is presented next cycle.
  assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && (!m_tvalid || m_tready) |=> m_tvalid && state == S_IDLE)
    else $error("result not presented");

endmodule

`default_nettype wire
